[rtl/assert_macros.svh]
// ----------------------------------------------------------------------------
// assertion macros
// shared concurrent assertion forms for the rtl
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");

// next-cycle implication
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

[rtl/sbd_pkg.sv]
// ----------------------------------------------------------------------------
// sbd_pkg
// types, constants and helpers for the stereo biquad decimator
// ----------------------------------------------------------------------------
`default_nettype none

package sbd_pkg;

  localparam int DATA_W = 48;
  localparam int ACC_W = 58;
  localparam int PRD_W = 53;
  localparam int COEF_W = 32;
  localparam int PC_W = 5;
  localparam int CFG_IDX_W = 8;

  localparam logic [1:0] DECIM_LAST = 2'd2;
  localparam logic [12:0] MAX_FRAME = 13'd4096;

  typedef logic signed [DATA_W-1:0] data_t;
  typedef logic signed [ACC_W-1:0] acc_t;
  typedef logic signed [PRD_W-1:0] prd_t;
  typedef logic signed [COEF_W-1:0] coef_w_t;

  localparam data_t DATA_MAX = 48'sh7FFF_FFFF_FFFF;
  localparam data_t DATA_MIN = -48'sh7FFF_FFFF_FFFF - 48'sd1;
  localparam logic signed [15:0] PCM_MAX = 16'sh7FFF;
  localparam logic signed [15:0] PCM_MIN = -16'sh7FFF - 16'sd1;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] REG_S1_B0 = 8'd0;
  localparam logic [CFG_IDX_W-1:0] REG_S1_A1 = 8'd1;
  localparam logic [CFG_IDX_W-1:0] REG_S1_A2 = 8'd2;
  localparam logic [CFG_IDX_W-1:0] REG_S2_B0 = 8'd3;
  localparam logic [CFG_IDX_W-1:0] REG_S2_A1 = 8'd4;
  localparam logic [CFG_IDX_W-1:0] REG_S2_A2 = 8'd5;
  localparam logic [CFG_IDX_W-1:0] REG_DC_POLE = 8'd6;
  localparam logic [CFG_IDX_W-1:0] REG_FRAME_LEN = 8'd7;

  // register reset values
  localparam coef_w_t RST_S1_B0 = 32'sd2184528;
  localparam coef_w_t RST_S1_A1 = -32'sd446140000;
  localparam coef_w_t RST_S1_A2 = 32'sd186445000;
  localparam coef_w_t RST_S2_B0 = 32'sd2399300;
  localparam coef_w_t RST_S2_A1 = -32'sd489978000;
  localparam coef_w_t RST_S2_A2 = 32'sd231140000;
  localparam logic [27:0] RST_DC_POLE = 28'd267093279;
  localparam logic [12:0] RST_FRAME_LEN = 13'd256;

  typedef struct packed {
    coef_w_t     s1_b0;
    coef_w_t     s1_a1;
    coef_w_t     s1_a2;
    coef_w_t     s2_b0;
    coef_w_t     s2_a1;
    coef_w_t     s2_a2;
    logic [27:0] dc_pole;
  } coef_t;

  typedef enum logic [1:0] {
    MUL_NONE,
    MUL_HI,
    MUL_LO
  } mul_op_e;

  typedef enum logic [1:0] {
    ASEL_X,
    ASEL_Y,
    ASEL_DCO
  } asel_e;

  typedef enum logic [2:0] {
    CSEL_S1_B0,
    CSEL_S1_A1,
    CSEL_S1_A2,
    CSEL_S2_B0,
    CSEL_S2_A1,
    CSEL_S2_A2,
    CSEL_DC_POLE
  } csel_e;

  typedef enum logic [2:0] {
    ALU_NONE,
    ALU_Y,
    ALU_Z0,
    ALU_Z1,
    ALU_DC
  } alu_op_e;

  typedef enum logic [1:0] {
    SEQ_NEXT,
    SEQ_SKIP,
    SEQ_EMIT,
    SEQ_END
  } seq_e;

  typedef struct packed {
    mul_op_e mul;
    asel_e   asel;
    csel_e   csel;
    alu_op_e alu;
    logic    stage;
    seq_e    seq;
  } ucode_t;

  typedef struct packed {
    logic   load;
    logic   en;
    ucode_t cw;
  } dp_ctrl_t;

  function automatic data_t sat48(acc_t v);
    data_t r;
    if (v > acc_t'(DATA_MAX)) begin
      r = DATA_MAX;
    end else if (v < acc_t'(DATA_MIN)) begin
      r = DATA_MIN;
    end else begin
      r = v[DATA_W-1:0];
    end
    return r;
  endfunction

endpackage

`default_nettype wire

[rtl/sbd_ucode_rom.sv]
// ----------------------------------------------------------------------------
// sbd_ucode_rom
// control store: one control word per step of the per-item program
// ----------------------------------------------------------------------------
`default_nettype none

module sbd_ucode_rom (
  input  wire logic [sbd_pkg::PC_W-1:0] pc_i,
  output sbd_pkg::ucode_t               cw_o
);

  function automatic sbd_pkg::ucode_t uw(sbd_pkg::mul_op_e mul, sbd_pkg::asel_e asel,
                                         sbd_pkg::csel_e csel, sbd_pkg::alu_op_e alu,
                                         logic stage, sbd_pkg::seq_e seq);
    sbd_pkg::ucode_t w;
    w.mul = mul;
    w.asel = asel;
    w.csel = csel;
    w.alu = alu;
    w.stage = stage;
    w.seq = seq;
    return w;
  endfunction

  always_comb begin
    case (pc_i)
      // stage 1: pb = b0*x, y = pb + z0
      5'd0:  cw_o = uw(sbd_pkg::MUL_HI, sbd_pkg::ASEL_X, sbd_pkg::CSEL_S1_B0,
                       sbd_pkg::ALU_NONE, 1'b0, sbd_pkg::SEQ_NEXT);
      5'd1:  cw_o = uw(sbd_pkg::MUL_LO, sbd_pkg::ASEL_X, sbd_pkg::CSEL_S1_B0,
                       sbd_pkg::ALU_NONE, 1'b0, sbd_pkg::SEQ_NEXT);
      5'd2:  cw_o = uw(sbd_pkg::MUL_NONE, sbd_pkg::ASEL_Y, sbd_pkg::CSEL_S1_B0,
                       sbd_pkg::ALU_Y, 1'b0, sbd_pkg::SEQ_NEXT);
      // stage 1 feedback
      5'd3:  cw_o = uw(sbd_pkg::MUL_HI, sbd_pkg::ASEL_Y, sbd_pkg::CSEL_S1_A1,
                       sbd_pkg::ALU_NONE, 1'b0, sbd_pkg::SEQ_NEXT);
      5'd4:  cw_o = uw(sbd_pkg::MUL_LO, sbd_pkg::ASEL_Y, sbd_pkg::CSEL_S1_A1,
                       sbd_pkg::ALU_NONE, 1'b0, sbd_pkg::SEQ_NEXT);
      5'd5:  cw_o = uw(sbd_pkg::MUL_HI, sbd_pkg::ASEL_Y, sbd_pkg::CSEL_S1_A2,
                       sbd_pkg::ALU_Z0, 1'b0, sbd_pkg::SEQ_NEXT);
      5'd6:  cw_o = uw(sbd_pkg::MUL_LO, sbd_pkg::ASEL_Y, sbd_pkg::CSEL_S1_A2,
                       sbd_pkg::ALU_NONE, 1'b0, sbd_pkg::SEQ_NEXT);
      // stage 2
      5'd7:  cw_o = uw(sbd_pkg::MUL_HI, sbd_pkg::ASEL_Y, sbd_pkg::CSEL_S2_B0,
                       sbd_pkg::ALU_Z1, 1'b0, sbd_pkg::SEQ_NEXT);
      5'd8:  cw_o = uw(sbd_pkg::MUL_LO, sbd_pkg::ASEL_Y, sbd_pkg::CSEL_S2_B0,
                       sbd_pkg::ALU_NONE, 1'b1, sbd_pkg::SEQ_NEXT);
      5'd9:  cw_o = uw(sbd_pkg::MUL_NONE, sbd_pkg::ASEL_Y, sbd_pkg::CSEL_S2_B0,
                       sbd_pkg::ALU_Y, 1'b1, sbd_pkg::SEQ_NEXT);
      5'd10: cw_o = uw(sbd_pkg::MUL_HI, sbd_pkg::ASEL_Y, sbd_pkg::CSEL_S2_A1,
                       sbd_pkg::ALU_NONE, 1'b1, sbd_pkg::SEQ_NEXT);
      5'd11: cw_o = uw(sbd_pkg::MUL_LO, sbd_pkg::ASEL_Y, sbd_pkg::CSEL_S2_A1,
                       sbd_pkg::ALU_NONE, 1'b1, sbd_pkg::SEQ_NEXT);
      5'd12: cw_o = uw(sbd_pkg::MUL_HI, sbd_pkg::ASEL_Y, sbd_pkg::CSEL_S2_A2,
                       sbd_pkg::ALU_Z0, 1'b1, sbd_pkg::SEQ_NEXT);
      5'd13: cw_o = uw(sbd_pkg::MUL_LO, sbd_pkg::ASEL_Y, sbd_pkg::CSEL_S2_A2,
                       sbd_pkg::ALU_NONE, 1'b1, sbd_pkg::SEQ_NEXT);
      // decimation branch, dc blocker
      5'd14: cw_o = uw(sbd_pkg::MUL_HI, sbd_pkg::ASEL_DCO, sbd_pkg::CSEL_DC_POLE,
                       sbd_pkg::ALU_Z1, 1'b1, sbd_pkg::SEQ_SKIP);
      5'd15: cw_o = uw(sbd_pkg::MUL_LO, sbd_pkg::ASEL_DCO, sbd_pkg::CSEL_DC_POLE,
                       sbd_pkg::ALU_NONE, 1'b0, sbd_pkg::SEQ_NEXT);
      5'd16: cw_o = uw(sbd_pkg::MUL_NONE, sbd_pkg::ASEL_DCO, sbd_pkg::CSEL_DC_POLE,
                       sbd_pkg::ALU_DC, 1'b0, sbd_pkg::SEQ_NEXT);
      5'd17: cw_o = uw(sbd_pkg::MUL_NONE, sbd_pkg::ASEL_DCO, sbd_pkg::CSEL_DC_POLE,
                       sbd_pkg::ALU_NONE, 1'b0, sbd_pkg::SEQ_EMIT);
      default: cw_o = uw(sbd_pkg::MUL_NONE, sbd_pkg::ASEL_X, sbd_pkg::CSEL_S1_B0,
                         sbd_pkg::ALU_NONE, 1'b0, sbd_pkg::SEQ_END);
    endcase
  end

endmodule

`default_nettype wire

[rtl/sbd_mac.sv]
// ----------------------------------------------------------------------------
// sbd_mac
// shared coefficient multiplier: floor(a * c / 2^28) in a high and a low pass
// ----------------------------------------------------------------------------
`default_nettype none

module sbd_mac (
  input  wire logic               clk_i,
  input  wire sbd_pkg::mul_op_e   op_i,
  input  wire sbd_pkg::data_t     a_i,
  input  wire sbd_pkg::coef_w_t   c_i,
  output sbd_pkg::prd_t           prd_o
);

  logic signed [32:0] mul_a;
  logic signed [64:0] prod;
  logic signed [64:0] sum;
  logic signed [63:0] p_q;
  sbd_pkg::prd_t      prd_q;

  // high pass uses a >>> 16, low pass the unsigned low 16 bits
  always_comb begin
    if (op_i == sbd_pkg::MUL_LO) begin
      mul_a = {17'd0, a_i[15:0]};
    end else begin
      mul_a = {a_i[47], a_i[47:16]};
    end
  end

  assign prod = 65'(mul_a) * 65'(c_i);
  assign sum = 65'(p_q) + (prod >>> 16);

  always_ff @(posedge clk_i) begin
    case (op_i)
      sbd_pkg::MUL_HI: p_q <= prod[63:0];
      sbd_pkg::MUL_LO: prd_q <= sum[64:12];
      default: ;
    endcase
  end

  assign prd_o = prd_q;

endmodule

`default_nettype wire

[rtl/sbd_datapath.sv]
// ----------------------------------------------------------------------------
// sbd_datapath
// signal registers, filter state, accumulator alu and output formatting
// ----------------------------------------------------------------------------
`default_nettype none

module sbd_datapath (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire sbd_pkg::dp_ctrl_t  ctrl_i,
  input  wire sbd_pkg::coef_t     coef_i,
  input  wire logic signed [31:0] left_i,
  input  wire logic signed [31:0] right_i,
  output logic signed [15:0]      sample_o
);

  sbd_pkg::data_t   x_q, y_q, dci_q, dco_q, mul_a, x_in;
  sbd_pkg::data_t   z0_q [2];
  sbd_pkg::data_t   z1_q [2];
  sbd_pkg::prd_t    pb_q, prd;
  sbd_pkg::coef_w_t mul_c;
  sbd_pkg::acc_t    acc;
  sbd_pkg::mul_op_e mac_op;
  logic             st;
  logic signed [24:0] lr_sum;
  logic signed [48:0] vb;
  logic signed [24:0] s;

  assign st = ctrl_i.cw.stage;
  assign mac_op = ctrl_i.en ? ctrl_i.cw.mul : sbd_pkg::MUL_NONE;

  // mono average with one fraction bit, in 16 fraction bits
  assign lr_sum = 25'($signed(left_i[31:8])) + 25'($signed(right_i[31:8]));
  assign x_in = {{8{lr_sum[24]}}, lr_sum, 15'd0};

  always_comb begin
    case (ctrl_i.cw.asel)
      sbd_pkg::ASEL_X:   mul_a = x_q;
      sbd_pkg::ASEL_Y:   mul_a = y_q;
      sbd_pkg::ASEL_DCO: mul_a = dco_q;
      default:           mul_a = x_q;
    endcase
  end

  always_comb begin
    case (ctrl_i.cw.csel)
      sbd_pkg::CSEL_S1_B0:   mul_c = coef_i.s1_b0;
      sbd_pkg::CSEL_S1_A1:   mul_c = coef_i.s1_a1;
      sbd_pkg::CSEL_S1_A2:   mul_c = coef_i.s1_a2;
      sbd_pkg::CSEL_S2_B0:   mul_c = coef_i.s2_b0;
      sbd_pkg::CSEL_S2_A1:   mul_c = coef_i.s2_a1;
      sbd_pkg::CSEL_S2_A2:   mul_c = coef_i.s2_a2;
      sbd_pkg::CSEL_DC_POLE: mul_c = $signed({4'd0, coef_i.dc_pole});
      default:               mul_c = coef_i.s1_b0;
    endcase
  end

  sbd_mac u_mac (
    .clk_i (clk_i),
    .op_i  (mac_op),
    .a_i   (mul_a),
    .c_i   (mul_c),
    .prd_o (prd)
  );

  always_comb begin
    case (ctrl_i.cw.alu)
      sbd_pkg::ALU_Y:  acc = sbd_pkg::acc_t'(prd) + sbd_pkg::acc_t'(z0_q[st]);
      sbd_pkg::ALU_Z0: acc = (sbd_pkg::acc_t'(pb_q) <<< 1) - sbd_pkg::acc_t'(prd)
                             + sbd_pkg::acc_t'(z1_q[st]);
      sbd_pkg::ALU_Z1: acc = sbd_pkg::acc_t'(pb_q) - sbd_pkg::acc_t'(prd);
      sbd_pkg::ALU_DC: acc = sbd_pkg::acc_t'(y_q) - sbd_pkg::acc_t'(dci_q)
                             + sbd_pkg::acc_t'(prd);
      default:         acc = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      z0_q[0] <= '0;
      z0_q[1] <= '0;
      z1_q[0] <= '0;
      z1_q[1] <= '0;
      dci_q <= '0;
      dco_q <= '0;
    end else if (ctrl_i.en) begin
      case (ctrl_i.cw.alu)
        sbd_pkg::ALU_Z0: z0_q[st] <= sbd_pkg::sat48(acc);
        sbd_pkg::ALU_Z1: z1_q[st] <= sbd_pkg::sat48(acc);
        sbd_pkg::ALU_DC: begin
          dci_q <= y_q;
          dco_q <= sbd_pkg::sat48(acc);
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.load) begin
      x_q <= x_in;
    end
    if (ctrl_i.en && ctrl_i.cw.alu == sbd_pkg::ALU_Y) begin
      pb_q <= prd;
      y_q <= sbd_pkg::sat48(acc);
    end
  end

  // truncate toward zero to integer, then floor shift by 8 and clip
  assign vb = 49'(dco_q) + (dco_q[47] ? 49'sd65535 : 49'sd0);
  assign s = vb[48:24];

  always_comb begin
    if (s > 25'(sbd_pkg::PCM_MAX)) begin
      sample_o = sbd_pkg::PCM_MAX;
    end else if (s < 25'(sbd_pkg::PCM_MIN)) begin
      sample_o = sbd_pkg::PCM_MIN;
    end else begin
      sample_o = s[15:0];
    end
  end

endmodule

`default_nettype wire

[rtl/stereo_biquad_decimator_dc_block_top.sv]
// ----------------------------------------------------------------------------
// stereo_biquad_decimator_dc_block_top
// stereo to mono, two lowpass biquads, decimate by 3, dc blocker, 16-bit pcm
// ----------------------------------------------------------------------------
// usage:
//   s_axis carries one stereo item: left word in tdata[31:0], right in [63:32].
//   m_axis returns one pcm sample for every third item; tlast marks the last
//   sample of each frame of frame_length samples.
//   cfg writes one coefficient or frame length per handshake, index 0 to 7;
//   other indexes are ignored. write only while the block is idle.
// program:
//   an item runs the accept step plus 15 microcode steps when it makes no
//   sample, and further dc blocker and output steps when it does. the step
//   count is set by the single 33x32 multiplier, which needs a high and a
//   low pass for each of the seven coefficient products.
// reset:
//   coefficients and frame length return to their defaults, filter state,
//   decimation phase and frame position are cleared.
// stall:
//   a sample waits in the output register; the next items are accepted and
//   run, and only an item that reaches its output step waits there.
// ----------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"

module stereo_biquad_decimator_dc_block_top (
  input  wire logic                             clk_i,
  input  wire logic                             rst_ni,
  input  wire logic                             s_axis_tvalid,
  output logic                                  s_axis_tready,
  input  wire logic [63:0]                      s_axis_tdata,  // left_word, right_word
  output logic                                  m_axis_tvalid,
  input  wire logic                             m_axis_tready,
  output logic [15:0]                           m_axis_tdata,  // pcm_sample
  output logic                                  m_axis_tlast,
  input  wire logic                             cfg_valid_i,
  output logic                                  cfg_ready_o,
  input  wire logic [sbd_pkg::CFG_IDX_W-1:0]    cfg_index_i,
  input  wire logic [31:0]                      cfg_data_i
);

  typedef enum logic {
    ST_IDLE,
    ST_RUN
  } state_e;

  state_e                   state_q, state_d;
  logic [sbd_pkg::PC_W-1:0] pc_q, pc_d;
  logic [1:0]               phase_q, phase_d;
  logic [11:0]              pos_q, pos_d;
  logic                     out_valid_q, out_valid_d;
  logic [15:0]              out_data_q, out_data_d;
  logic                     out_last_q, out_last_d;

  sbd_pkg::coef_t    coef_q;
  logic [12:0]       frame_len_q;
  logic [12:0]       len;
  logic              last;
  sbd_pkg::ucode_t   cw;
  sbd_pkg::dp_ctrl_t dp_ctrl;
  logic signed [15:0] sample;
  logic              accept, stall, emit;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      coef_q.s1_b0 <= sbd_pkg::RST_S1_B0;
      coef_q.s1_a1 <= sbd_pkg::RST_S1_A1;
      coef_q.s1_a2 <= sbd_pkg::RST_S1_A2;
      coef_q.s2_b0 <= sbd_pkg::RST_S2_B0;
      coef_q.s2_a1 <= sbd_pkg::RST_S2_A1;
      coef_q.s2_a2 <= sbd_pkg::RST_S2_A2;
      coef_q.dc_pole <= sbd_pkg::RST_DC_POLE;
      frame_len_q <= sbd_pkg::RST_FRAME_LEN;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        sbd_pkg::REG_S1_B0:     coef_q.s1_b0 <= cfg_data_i;
        sbd_pkg::REG_S1_A1:     coef_q.s1_a1 <= cfg_data_i;
        sbd_pkg::REG_S1_A2:     coef_q.s1_a2 <= cfg_data_i;
        sbd_pkg::REG_S2_B0:     coef_q.s2_b0 <= cfg_data_i;
        sbd_pkg::REG_S2_A1:     coef_q.s2_a1 <= cfg_data_i;
        sbd_pkg::REG_S2_A2:     coef_q.s2_a2 <= cfg_data_i;
        sbd_pkg::REG_DC_POLE:   coef_q.dc_pole <= cfg_data_i[27:0];
        sbd_pkg::REG_FRAME_LEN: frame_len_q <= cfg_data_i[12:0];
        default: ;
      endcase
    end
  end

  sbd_ucode_rom u_rom (
    .pc_i (pc_q),
    .cw_o (cw)
  );

  assign s_axis_tready = (state_q == ST_IDLE);
  assign accept = s_axis_tvalid && s_axis_tready;
  assign stall = (cw.seq == sbd_pkg::SEQ_EMIT) && out_valid_q && !m_axis_tready;
  assign emit = (state_q == ST_RUN) && (cw.seq == sbd_pkg::SEQ_EMIT) && !stall;

  assign dp_ctrl.load = accept;
  assign dp_ctrl.en = (state_q == ST_RUN) && !stall;
  assign dp_ctrl.cw = cw;

  sbd_datapath u_dp (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .ctrl_i   (dp_ctrl),
    .coef_i   (coef_q),
    .left_i   (s_axis_tdata[31:0]),
    .right_i  (s_axis_tdata[63:32]),
    .sample_o (sample)
  );

  always_comb begin
    if (frame_len_q == '0) begin
      len = 13'd1;
    end else if (frame_len_q > sbd_pkg::MAX_FRAME) begin
      len = sbd_pkg::MAX_FRAME;
    end else begin
      len = frame_len_q;
    end
  end

  assign last = ({1'b0, pos_q} + 13'd1) >= len;

  always_comb begin
    state_d = state_q;
    pc_d = pc_q;
    phase_d = phase_q;
    pos_d = pos_q;
    out_valid_d = out_valid_q && !m_axis_tready;
    out_data_d = out_data_q;
    out_last_d = out_last_q;
    case (state_q)
      ST_IDLE: begin
        if (accept) begin
          state_d = ST_RUN;
          pc_d = '0;
        end
      end
      ST_RUN: begin
        if (!stall) begin
          case (cw.seq)
            sbd_pkg::SEQ_NEXT: pc_d = pc_q + 5'd1;
            sbd_pkg::SEQ_SKIP: begin
              if (phase_q != sbd_pkg::DECIM_LAST) begin
                phase_d = phase_q + 2'd1;
                state_d = ST_IDLE;
              end else begin
                phase_d = '0;
                pc_d = pc_q + 5'd1;
              end
            end
            sbd_pkg::SEQ_EMIT: begin
              out_valid_d = 1'b1;
              out_data_d = sample;
              out_last_d = last;
              pos_d = last ? '0 : pos_q + 12'd1;
              state_d = ST_IDLE;
            end
            default: state_d = ST_IDLE;
          endcase
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      pc_q <= '0;
      phase_q <= '0;
      pos_q <= '0;
      out_valid_q <= 1'b0;
      out_data_q <= '0;
      out_last_q <= 1'b0;
    end else begin
      state_q <= state_d;
      pc_q <= pc_d;
      phase_q <= phase_d;
      pos_q <= pos_d;
      out_valid_q <= out_valid_d;
      out_data_q <= out_data_d;
      out_last_q <= out_last_d;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata = out_data_q;
  assign m_axis_tlast = out_last_q;

  `ASSERT_NEXT(a_accept_starts_program, clk_i, rst_ni, accept,
               state_q == ST_RUN && pc_q == '0)
  `ASSERT_IMPLIES(a_no_overwrite, clk_i, rst_ni, m_axis_tvalid && !m_axis_tready, !emit)
  `ASSERT_NEXT(a_emit_on_phase_wrap, clk_i, rst_ni, emit, m_axis_tvalid && phase_q == '0)

endmodule

`default_nettype wire

[sim/sbd_pcm_checker.sv]
// ----------------------------------------------------------------------------
// sbd_pcm_checker
// watches the config, input and pcm output channels of the stereo biquad
// decimator, predicts every pcm sample and its frame-end flag with its own
// fixed-point copy of the filter chain, and compares them in order
// ----------------------------------------------------------------------------
module sbd_pcm_checker
  import sbd_pkg::*;
(
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 s_axis_tvalid,
  input  logic                 s_axis_tready,
  input  logic [63:0]          s_axis_tdata,   // left_word, right_word
  input  logic                 m_axis_tvalid,
  input  logic                 m_axis_tready,
  input  logic [15:0]          m_axis_tdata,   // pcm_sample
  input  logic                 m_axis_tlast,
  input  logic                 cfg_valid_i,
  input  logic                 cfg_ready_i,
  input  logic [CFG_IDX_W-1:0] cfg_index_i,
  input  logic [31:0]          cfg_data_i,
  output int                   mismatches_o,
  output int                   pending_o
);

  localparam int COEF_FRAC = 28;

  typedef struct packed {
    logic signed [15:0] pcm;
    logic               frame_end;
  } pcm_out_t;

  coef_w_t     b0_c [2];
  coef_w_t     a1_c [2];
  coef_w_t     a2_c [2];
  logic [27:0] pole_c;
  logic [12:0] flen_c;

  data_t       delay_z [2][2];
  data_t       dc_x1;
  data_t       dc_y1;
  logic [1:0]  decim_ph;
  logic [11:0] frame_pos;
  pcm_out_t    due_pcm [$];
  int          faults;

  // floor(a * c / 2^28), exact
  function automatic longint coef_scale(longint a, longint c);
    logic signed [95:0] wa, wc, p;
    wa = a;
    wc = c;
    p = wa * wc;
    return longint'(p >>> COEF_FRAC);
  endfunction

  function automatic data_t clamp48(longint v);
    if (v > longint'(DATA_MAX)) return DATA_MAX;
    if (v < longint'(DATA_MIN)) return DATA_MIN;
    return data_t'(v);
  endfunction

  // transposed direct form ii, b1 = 2*b0, b2 = b0
  function automatic data_t biquad_step(int st, data_t x);
    longint pb;
    data_t  y;
    pb = coef_scale(x, b0_c[st]);
    y = clamp48(pb + delay_z[st][0]);
    delay_z[st][0] = clamp48(2 * pb - coef_scale(y, a1_c[st]) + delay_z[st][1]);
    delay_z[st][1] = clamp48(pb - coef_scale(y, a2_c[st]));
    return y;
  endfunction

  function automatic void predict_frame(logic [63:0] frame);
    logic signed [31:0] lw, rw;
    longint   lv, rv, dcv, ip, sv, pole_v;
    data_t    y;
    int       flen;
    logic     last;
    pcm_out_t o;
    lw = frame[31:0];
    rw = frame[63:32];
    lv = lw;
    rv = rw;
    lv = lv >>> 8;
    rv = rv >>> 8;
    y = biquad_step(0, data_t'((lv + rv) * 32768));
    y = biquad_step(1, y);
    if (decim_ph != DECIM_LAST) begin
      decim_ph = decim_ph + 2'd1;
      return;
    end
    decim_ph = '0;
    pole_v = pole_c;
    dcv = clamp48(longint'(y) - longint'(dc_x1) + coef_scale(dc_y1, pole_v));
    dc_x1 = y;
    dc_y1 = data_t'(dcv);
    // integer part truncated toward zero
    ip = (dcv < 0) ? -((-dcv) >>> 16) : (dcv >>> 16);
    sv = ip >>> 8;
    if (sv > longint'(PCM_MAX)) sv = longint'(PCM_MAX);
    else if (sv < longint'(PCM_MIN)) sv = longint'(PCM_MIN);
    flen = flen_c;
    if (flen < 1) flen = 1;
    else if (flen > int'(MAX_FRAME)) flen = MAX_FRAME;
    last = (int'(frame_pos) + 1 >= flen);
    frame_pos = last ? 12'd0 : frame_pos + 12'd1;
    o.pcm = sv[15:0];
    o.frame_end = last;
    due_pcm.push_back(o);
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    pcm_out_t want;
    if (!rst_ni) begin
      b0_c[0] = RST_S1_B0;
      a1_c[0] = RST_S1_A1;
      a2_c[0] = RST_S1_A2;
      b0_c[1] = RST_S2_B0;
      a1_c[1] = RST_S2_A1;
      a2_c[1] = RST_S2_A2;
      pole_c = RST_DC_POLE;
      flen_c = RST_FRAME_LEN;
      for (int s = 0; s < 2; s++) begin
        delay_z[s][0] = '0;
        delay_z[s][1] = '0;
      end
      dc_x1 = '0;
      dc_y1 = '0;
      decim_ph = '0;
      frame_pos = '0;
      due_pcm.delete();
      faults = 0;
    end else begin
      if (cfg_valid_i && cfg_ready_i) begin
        case (cfg_index_i)
          REG_S1_B0:     b0_c[0] = cfg_data_i;
          REG_S1_A1:     a1_c[0] = cfg_data_i;
          REG_S1_A2:     a2_c[0] = cfg_data_i;
          REG_S2_B0:     b0_c[1] = cfg_data_i;
          REG_S2_A1:     a1_c[1] = cfg_data_i;
          REG_S2_A2:     a2_c[1] = cfg_data_i;
          REG_DC_POLE:   pole_c = cfg_data_i[27:0];
          REG_FRAME_LEN: flen_c = cfg_data_i[12:0];
          default: ;
        endcase
      end
      if (s_axis_tvalid && s_axis_tready) predict_frame(s_axis_tdata);
      if (m_axis_tvalid && m_axis_tready) begin
        if (due_pcm.size() == 0) begin
          $error("pcm_sample: item with nothing expected, actual %0d",
                 $signed(m_axis_tdata));
          faults++;
        end else begin
          want = due_pcm.pop_front();
          if (m_axis_tdata !== want.pcm) begin
            $error("pcm_sample: expected %0d actual %0d", want.pcm, $signed(m_axis_tdata));
            faults++;
          end
          if (m_axis_tlast !== want.frame_end) begin
            $error("frame_end: expected %0d actual %0d", want.frame_end, m_axis_tlast);
            faults++;
          end
        end
      end
    end
    pending_o <= due_pcm.size();
    mismatches_o <= faults;
  end

endmodule

[sim/tb_top.sv]
// ----------------------------------------------------------------------------
// tb_top
// drives the stereo biquad decimator with directed extremes and random audio
// frames over several coefficient and frame-length settings, with random
// gaps on both streams and one long output stall; the checker judges results
// ----------------------------------------------------------------------------
module tb_top;
  import sbd_pkg::*;

  localparam int CYCLE_LIMIT = 500000;
  localparam int DRAIN_CYCLES = 40;
  localparam int LONG_STALL = 400;

  logic                 clk_i = 1'b0;
  logic                 rst_ni = 1'b0;
  logic                 s_axis_tvalid;
  logic                 s_axis_tready;
  logic [63:0]          s_axis_tdata;   // left_word, right_word
  logic                 m_axis_tvalid;
  logic                 m_axis_tready;
  logic [15:0]          m_axis_tdata;   // pcm_sample
  logic                 m_axis_tlast;
  logic                 cfg_valid_i;
  logic                 cfg_ready_o;
  logic [CFG_IDX_W-1:0] cfg_index_i;
  logic [31:0]          cfg_data_i;

  int mismatches;
  int pending;
  int cycles = 0;
  bit calm = 1'b0;

  always #6 clk_i = ~clk_i;

  stereo_biquad_decimator_dc_block_top dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i)
  );

  sbd_pcm_checker chk (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_i   (cfg_ready_o),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i),
    .mismatches_o  (mismatches),
    .pending_o     (pending)
  );

  always @(posedge clk_i) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("Verification failed");
      $finish;
    end
  end

  // pcm sink: random stall bursts plus one long hold-off
  initial begin : sink
    int  sunk;
    bit  held_long;
    sunk = 0;
    held_long = 1'b0;
    m_axis_tready <= 1'b0;
    wait (rst_ni);
    forever begin
      if (!held_long && sunk >= 130) begin
        held_long = 1'b1;
        m_axis_tready <= 1'b0;
        repeat (LONG_STALL) @(posedge clk_i);
      end else if (!calm && $urandom_range(0, 5) == 0) begin
        m_axis_tready <= 1'b0;
        repeat ($urandom_range(1, 8)) @(posedge clk_i);
      end
      m_axis_tready <= 1'b1;
      @(posedge clk_i);
      if (m_axis_tvalid) sunk++;
    end
  end

  task automatic push_frame(input logic [31:0] left, input logic [31:0] right);
    if (!calm && $urandom_range(0, 4) == 0) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 8)) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= {right, left};
    do @(posedge clk_i); while (!s_axis_tready);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [31:0] val);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= val;
    do @(posedge clk_i); while (!cfg_ready_o);
  endtask

  task automatic load_regs(input logic [31:0] s1b0, s1a1, s1a2, s2b0, s2a1, s2a2,
                           input logic [31:0] pole, flen);
    write_reg(REG_S1_B0, s1b0);
    write_reg(REG_S1_A1, s1a1);
    write_reg(REG_S1_A2, s1a2);
    write_reg(REG_S2_B0, s2b0);
    write_reg(REG_S2_A1, s2a1);
    write_reg(REG_S2_A2, s2a2);
    write_reg(REG_DC_POLE, pole);
    write_reg(REG_FRAME_LEN, flen);
    // unmapped index, must be ignored
    if ($urandom_range(0, 2) == 0)
      write_reg(CFG_IDX_W'($urandom_range(REG_FRAME_LEN + 1, 255)), $urandom());
    cfg_valid_i <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic drain();
    s_axis_tvalid <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  function automatic logic [31:0] audio_word();
    logic signed [31:0] w;
    w = $urandom();
    case ($urandom_range(0, 7))
      0:       w = $urandom_range(0, 1) ? 32'h7FFF_FFFF : 32'h8000_0000;
      1, 2, 3: w = w >>> $urandom_range(4, 20);
      default: ;
    endcase
    return w;
  endfunction

  function automatic logic [31:0] nudge(coef_w_t c);
    return c + $urandom_range(0, 1 << 19) - (1 << 18);
  endfunction

  task automatic random_regs();
    logic [31:0] flen;
    logic [31:0] pole;
    case ($urandom_range(0, 5))
      0:       flen = 32'd1;
      1:       flen = 32'(MAX_FRAME);
      2:       flen = $urandom();
      default: flen = $urandom_range(2, 12);
    endcase
    pole = {4'($urandom_range(0, 15)), 28'(RST_DC_POLE - $urandom_range(0, 1 << 22))};
    if ($urandom_range(0, 3) == 0)
      load_regs($urandom(), $urandom(), $urandom(), $urandom(), $urandom(), $urandom(),
                $urandom(), flen);
    else
      load_regs(nudge(RST_S1_B0), nudge(RST_S1_A1), nudge(RST_S1_A2),
                nudge(RST_S2_B0), nudge(RST_S2_A1), nudge(RST_S2_A2), pole, flen);
  endtask

  initial begin : stimulus
    s_axis_tvalid <= 1'b0;
    s_axis_tdata <= '0;
    cfg_valid_i <= 1'b0;
    cfg_index_i <= '0;
    cfg_data_i <= '0;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // field extremes at reset settings
    push_frame(32'h0000_0000, 32'h0000_0000);
    push_frame(32'h7FFF_FFFF, 32'h7FFF_FFFF);
    push_frame(32'h8000_0000, 32'h8000_0000);
    push_frame(32'h7FFF_FFFF, 32'h8000_0000);
    push_frame(32'h8000_0000, 32'h7FFF_FFFF);
    push_frame(32'hFFFF_FFFF, 32'hFFFF_FFFF);
    push_frame(32'h0000_00FF, 32'h0000_00FF);
    push_frame(32'h0000_0100, 32'h0000_0000);
    push_frame(32'hFFFF_FF00, 32'h0000_0000);
    push_frame(32'h5555_5555, 32'hAAAA_AAAA);
    push_frame(32'hAAAA_AAAA, 32'h5555_5555);
    repeat (6) push_frame(32'h7FFF_FF00, 32'h7FFF_FF00);
    repeat (7) push_frame(32'h8000_0000, 32'h8000_0000);
    drain();

    // extreme coefficients, frame length zero, saturation and clipping
    load_regs(32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000,
              32'h7FFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_E000);
    write_reg(8'hFF, 32'hDEAD_BEEF);
    cfg_valid_i <= 1'b0;
    @(posedge clk_i);
    repeat (90) push_frame(audio_word(), audio_word());
    drain();

    // opposite extremes, frame length above the maximum
    load_regs(32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000, 32'h8000_0000, 32'h7FFF_FFFF,
              32'h8000_0000, 32'h0000_0000, 32'h0000_1FFF);
    repeat (90) push_frame(audio_word(), audio_word());
    drain();

    // default filter, short frames; the long sink stall lands here
    load_regs(RST_S1_B0, RST_S1_A1, RST_S1_A2, RST_S2_B0, RST_S2_A1, RST_S2_A2,
              32'(RST_DC_POLE), 32'd5);
    repeat (300) push_frame(audio_word(), audio_word());
    drain();

    // frame length lowered below the current position
    load_regs(RST_S1_B0, RST_S1_A1, RST_S1_A2, RST_S2_B0, RST_S2_A1, RST_S2_A2,
              32'(RST_DC_POLE), 32'd100);
    repeat (150) push_frame(audio_word(), audio_word());
    drain();
    write_reg(REG_FRAME_LEN, 32'd10);
    write_reg(CFG_IDX_W'(REG_FRAME_LEN + 1), $urandom());
    cfg_valid_i <= 1'b0;
    @(posedge clk_i);
    repeat (60) push_frame(audio_word(), audio_word());
    drain();

    for (int p = 0; p < 6; p++) begin
      random_regs();
      repeat ($urandom_range(60, 90)) push_frame(audio_word(), audio_word());
      drain();
    end

    calm = 1'b1;
    random_regs();
    repeat (120) push_frame(audio_word(), audio_word());
    drain();

    if (mismatches == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
